@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define DIL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dil_pkg.sv @@
// Types, codes and constants of the delta ID list decoder.
// Used by every module of the block; depends on nothing.
package dil_pkg;

  // Width of the decoded IDs; sums wrap at this width (8 to 32).
  localparam int ID_WIDTH = 32;
  localparam int PID_W    = 32;
  localparam int CNT_W    = 32;
  localparam int ACC_W    = 32;
  localparam int REPS_W   = 5;

  // Queue depth between front and back, a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_CODE  = 1'b1;

  // Code byte classes.
  localparam logic [7:0] CODE_LIT_MAX = 8'h7F;
  localparam logic [7:0] CODE_NIB_MAX = 8'hDF;
  localparam logic [7:0] CODE_TOP_BIT = 8'hE1;
  localparam logic [7:0] CODE_RUN_MIN = 8'hF0;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_UNUSED   = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;

  // Command kinds passed from front to back.
  localparam logic [2:0] K_START  = 3'd0;
  localparam logic [2:0] K_DELTA  = 3'd1;
  localparam logic [2:0] K_RUN    = 3'd2;
  localparam logic [2:0] K_UNUSED = 3'd3;
  localparam logic [2:0] K_CHECK  = 3'd4;

  typedef struct packed {
    logic             opcode;
    logic [31:0]      first_id;
    logic [31:0]      expected_count;
    logic [7:0]       code_byte;
    logic             end_of_record;
  } in_t;

  typedef struct packed {
    logic [PID_W-1:0] pattern_id;
    logic             id_valid;
    logic [1:0]       status;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ACC_W-1:0]  value;
    logic [CNT_W-1:0]  expect_cnt;
    logic [REPS_W-1:0] reps;
    logic              eor;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ design/dil_front.sv @@
// Front end: accepts requests, folds delta nibbles into the accumulator
// and pushes one command per result-producing request. Depends on dil_pkg.
module dil_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dil_pkg::in_t     in_data,
  input  dil_pkg::q_stat_t q_stat,
  output logic             push,
  output dil_pkg::cmd_t    push_cmd
);

  logic [dil_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                      take;
  logic                      need_push;
  logic [4:0]                nib_shift;

  assign in_ready  = !q_stat.full;
  assign take      = in_valid && in_ready;
  assign nib_shift = 5'd7 + {in_data.code_byte[6:4], 2'b00};

  always_comb begin
    acc_nxt             = acc_r;
    need_push           = 1'b1;
    push_cmd.kind       = dil_pkg::K_UNUSED;
    push_cmd.value      = '0;
    push_cmd.expect_cnt = in_data.expected_count;
    push_cmd.reps       = '0;
    push_cmd.eor        = in_data.end_of_record;
    if (in_data.opcode == dil_pkg::OP_START) begin
      push_cmd.kind  = dil_pkg::K_START;
      push_cmd.value = in_data.first_id;
      acc_nxt        = '0;
    end else if (in_data.code_byte <= dil_pkg::CODE_LIT_MAX) begin
      push_cmd.kind  = dil_pkg::K_DELTA;
      push_cmd.value = acc_r | dil_pkg::ACC_W'(in_data.code_byte);
      acc_nxt        = '0;
    end else if (in_data.code_byte <= dil_pkg::CODE_NIB_MAX) begin
      // Nibble lands at bit 7, 11, ... 27; only an end of record needs the back.
      acc_nxt       = acc_r | (dil_pkg::ACC_W'(in_data.code_byte[3:0]) << nib_shift);
      push_cmd.kind = dil_pkg::K_CHECK;
      need_push     = in_data.end_of_record;
    end else if (in_data.code_byte == dil_pkg::CODE_TOP_BIT) begin
      acc_nxt       = acc_r | {1'b1, {(dil_pkg::ACC_W-1){1'b0}}};
      push_cmd.kind = dil_pkg::K_CHECK;
      need_push     = in_data.end_of_record;
    end else if (in_data.code_byte >= dil_pkg::CODE_RUN_MIN) begin
      push_cmd.kind = dil_pkg::K_RUN;
      push_cmd.reps = dil_pkg::REPS_W'(in_data.code_byte[3:0]) + dil_pkg::REPS_W'(2);
    end
  end

  assign push = take && need_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (take) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

@@ design/dil_fifo.sv @@
// Short command queue between front and back.
// Depends on dil_pkg for the command type and depth.
module dil_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dil_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output dil_pkg::cmd_t    head,
  output dil_pkg::q_stat_t q_stat
);

  dil_pkg::cmd_t               mem_r [dil_pkg::QUEUE_DEPTH];
  logic [dil_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [dil_pkg::QPTR_W:0]    cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == (dil_pkg::QPTR_W+1)'(dil_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ design/dil_back.sv @@
// Back end: runs queued commands, keeps previous ID and counts,
// and drives the registered result channel. Depends on dil_pkg.
module dil_back (
  input  logic             clk,
  input  logic             rst_n,
  input  dil_pkg::cmd_t    head,
  input  dil_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output dil_pkg::out_t    out_data
);

  logic [dil_pkg::ID_WIDTH-1:0] prev_r, prev_nxt;
  logic [dil_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [dil_pkg::CNT_W-1:0]    target_r, target_nxt;
  logic [dil_pkg::REPS_W-1:0]   rep_r, rep_nxt;
  logic                         xtra_r, xtra_nxt;
  logic                         out_valid_r;
  dil_pkg::out_t                out_r;

  logic                         go, produce, last, mism;
  logic [dil_pkg::CNT_W-1:0]    base, inc, tgt;
  logic [dil_pkg::ID_WIDTH-1:0] emit_id;
  dil_pkg::out_t                res;

  assign go        = !q_stat.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    base    = (head.kind == dil_pkg::K_START) ? '0 : count_r;
    inc     = (base == dil_pkg::CNT_MAX) ? base : base + 1'b1;
    tgt     = (head.kind == dil_pkg::K_START) ? head.expect_cnt : target_r;
    case (head.kind)
      dil_pkg::K_START: emit_id = head.value[dil_pkg::ID_WIDTH-1:0];
      dil_pkg::K_DELTA: emit_id = prev_r + head.value[dil_pkg::ID_WIDTH-1:0]
                                  + dil_pkg::ID_WIDTH'(1);
      default:          emit_id = prev_r + dil_pkg::ID_WIDTH'(1);
    endcase
  end

  always_comb begin
    produce    = 1'b0;
    pop        = 1'b0;
    last       = 1'b1;
    mism       = 1'b0;
    res        = '0;
    prev_nxt   = prev_r;
    count_nxt  = count_r;
    target_nxt = target_r;
    rep_nxt    = rep_r;
    xtra_nxt   = xtra_r;
    if (go) begin
      unique case (head.kind) inside
        dil_pkg::K_START, dil_pkg::K_DELTA, dil_pkg::K_RUN: begin
          last = (head.kind != dil_pkg::K_RUN) ||
                 (rep_r == head.reps - dil_pkg::REPS_W'(1));
          mism = last && head.eor && (inc != tgt);
          produce         = 1'b1;
          prev_nxt        = emit_id;
          count_nxt       = inc;
          target_nxt      = tgt;
          res.pattern_id  = dil_pkg::PID_W'(emit_id);
          res.id_valid    = 1'b1;
          res.status      = mism ? dil_pkg::STAT_MISMATCH : dil_pkg::STAT_OK;
          res.last_of_run = last;
          pop             = last;
          rep_nxt         = last ? '0 : rep_r + 1'b1;
        end
        dil_pkg::K_UNUSED: begin
          produce = 1'b1;
          if (!xtra_r) begin
            mism            = head.eor && (count_r != target_r);
            res.status      = dil_pkg::STAT_UNUSED;
            res.last_of_run = !mism;
            xtra_nxt        = mism;
            pop             = !mism;
          end else begin
            res.status      = dil_pkg::STAT_MISMATCH;
            res.last_of_run = 1'b1;
            xtra_nxt        = 1'b0;
            pop             = 1'b1;
          end
        end
        dil_pkg::K_CHECK: begin
          produce         = (count_r != target_r);
          res.status      = dil_pkg::STAT_MISMATCH;
          res.last_of_run = 1'b1;
          pop             = 1'b1;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      count_r     <= '0;
      target_r    <= '0;
      rep_r       <= '0;
      xtra_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      count_r  <= count_nxt;
      target_r <= target_nxt;
      rep_r    <= rep_nxt;
      xtra_r   <= xtra_nxt;
      if (produce)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

@@ design/delta_id_list_decoder_top.sv @@
// Delta ID list decoder, top level. An accepted request is written to the
// command queue, and its result to the output register after that.
// Throughput: one request per cycle while the queue is not full; a run
// code yields N+2 IDs, an unused code closing a mismatched record two results.
// Reset (rst_n low, synchronous) clears IDs, counts, accumulator and queue.
// Depends on dil_pkg, dil_front, dil_fifo and dil_back.
module delta_id_list_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dil_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dil_pkg::out_t out_data
);

  // Front to queue: one command per request that yields results.
  logic             push;
  dil_pkg::cmd_t    push_cmd;
  // Queue to back: head command and fill status.
  dil_pkg::cmd_t    head;
  dil_pkg::q_stat_t q_stat;
  logic             pop;

  // Classify requests and hold the delta accumulator; stall only on a full queue.
  dil_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple the two sides so a long run does not block accepting requests.
  dil_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Emit IDs and status results; advance the queue on an item's final result.
  dil_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/dil_checker.sv @@
// Port-level checks of the delta ID list decoder, bound to its top level.
// Depends on dil_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dil_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input dil_pkg::out_t out_data
);

  `DIL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DIL_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")
  `DIL_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> !out_valid, "result shown right after reset")
  `DIL_ASSERT(a_id_status, out_valid && out_data.id_valid |-> out_data.status != dil_pkg::STAT_UNUSED, "decoded id flagged unused")
  `DIL_ASSERT(a_flag_only, out_valid && !out_data.id_valid |-> out_data.pattern_id == '0 && out_data.status != dil_pkg::STAT_OK, "empty result without flag")

endmodule

bind delta_id_list_decoder_top dil_checker u_dil_checker (.*);
